// ----- rtl/isp_pkg.sv -----
`default_nettype none
package isp_pkg;

	localparam int STENCIL_POINTS_DEF = 4;

	localparam int COORD_W  = 32;
	localparam int INDEX_W  = 16;
	localparam int TOL_W    = 16;
	localparam int FRAC_W   = 16;
	localparam int STATUS_W = 3;

	// divider: 49 bit numerator magnitude, padded to whole groups
	localparam int DIV_BITS   = 4;
	localparam int NUM_BITS   = COORD_W + 1 + FRAC_W;
	localparam int DIV_STAGES = (NUM_BITS + DIV_BITS - 1) / DIV_BITS;
	localparam int NUM_W      = DIV_STAGES * DIV_BITS;
	localparam int Q_W        = NUM_W + 1;

	localparam logic [3:0] CFG_ORIGIN   = 4'd0;
	localparam logic [3:0] CFG_SPACING  = 4'd1;
	localparam logic [3:0] CFG_IMIN     = 4'd2;
	localparam logic [3:0] CFG_IMAX     = 4'd3;
	localparam logic [3:0] CFG_OFF_LO   = 4'd4;
	localparam logic [3:0] CFG_OFF_HI   = 4'd5;
	localparam logic [3:0] CFG_EXT_LO   = 4'd6;
	localparam logic [3:0] CFG_EXT_HI   = 4'd7;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_BELOW  = 3'd1,
		ST_ABOVE  = 3'd2,
		ST_TINY   = 3'd3,
		ST_DXZERO = 3'd4
	} status_t;

	typedef struct packed {
		logic              vld;
		logic              neg;
		logic [31:0]       rem;
		logic [NUM_W-1:0]  num;
		logic [NUM_W-1:0]  quo;
	} div_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin;
		logic signed [COORD_W-1:0] spacing;
		logic signed [INDEX_W-1:0] imin;
		logic signed [INDEX_W-1:0] imax;
		logic [TOL_W-1:0]          off_lo;
		logic [TOL_W-1:0]          off_hi;
		logic [TOL_W-1:0]          ext_lo;
		logic [TOL_W-1:0]          ext_hi;
	} cfg_t;

endpackage
`default_nettype wire

// ----- rtl/isp_div_stage.sv -----
`default_nettype none
module isp_div_stage
	import isp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic [31:0] dmag,
	input  div_t             d_in,
	output div_t             d_out
);

	div_t nx;

	always_comb begin
		logic [32:0] r;
		nx = d_in;
		for (int b = 0; b < DIV_BITS; b++) begin
			r = {nx.rem, nx.num[NUM_W-1]};
			nx.num = {nx.num[NUM_W-2:0], 1'b0};
			if (r >= {1'b0, dmag}) begin
				r = r - {1'b0, dmag};
				nx.quo = {nx.quo[NUM_W-2:0], 1'b1};
			end else begin
				nx.quo = {nx.quo[NUM_W-2:0], 1'b0};
			end
			nx.rem = r[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out <= nx;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/isp_post.sv -----
`default_nettype none
module isp_post
	import isp_pkg::*;
#(
	parameter int STENCIL_POINTS = STENCIL_POINTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  cfg_t                            cfg,
	input  div_t                            d_in,
	output logic                            vld_s3,
	output logic [STATUS_W-1:0]             status_s3,
	output logic signed [INDEX_W-1:0]       center_s3,
	output logic signed [COORD_W-1:0]       rel_s3
);

	localparam int PTS_ABOVE = STENCIL_POINTS / 2;
	localparam int PTS_BELOW = STENCIL_POINTS - PTS_ABOVE - 1;
	localparam bit EVEN     = (STENCIL_POINTS % 2) == 0;
	localparam int CMIN     = EVEN ? 0 : -(1 << (FRAC_W - 1));
	localparam int CMAX     = EVEN ? (1 << FRAC_W) : (1 << (FRAC_W - 1));
	localparam int C_W      = INDEX_W + 2;

	localparam logic signed [Q_W-1:0] MRP_Q  = Q_W'(PTS_ABOVE);
	localparam logic signed [Q_W-1:0] MRM_Q  = Q_W'(PTS_BELOW);
	localparam logic signed [Q_W-1:0] CMIN_Q = Q_W'(CMIN);
	localparam logic signed [Q_W-1:0] CMAX_Q = Q_W'(CMAX);
	localparam logic signed [Q_W-1:0] HALF_Q = Q_W'(1 << (FRAC_W - 1));
	localparam logic signed [C_W-1:0] MRP_C  = C_W'(PTS_ABOVE);
	localparam logic signed [C_W-1:0] MRM_C  = C_W'(PTS_BELOW);
	localparam logic signed [C_W-1:0] SP_C   = C_W'(STENCIL_POINTS);

	logic                    vld_s1, vld_s2;
	logic signed [Q_W-1:0]   q_s1, q_s2;
	logic [STATUS_W-1:0]     st_s2;
	logic signed [C_W-1:0]   c_s2;

	logic signed [Q_W-1:0]   q_nx, imin_q, imax_q, lo_e, hi_e, lo_o, hi_o, half_t, c_full;
	logic signed [C_W-1:0]   imin_c, imax_c, span, c_lo, c_hi, c_cl;
	logic [STATUS_W-1:0]     st_nx;
	logic signed [Q_W-1:0]   rel_full;

	always_comb begin
		q_nx = $signed({1'b0, d_in.quo});
		if (d_in.neg) begin
			q_nx = -q_nx - Q_W'(d_in.rem != '0);
		end
	end

	always_comb begin
		half_t = '0;
		imin_c = C_W'(cfg.imin);
		imax_c = C_W'(cfg.imax);
		span   = imax_c - imin_c + C_W'(1);
		imin_q = Q_W'(cfg.imin) <<< FRAC_W;
		imax_q = Q_W'(cfg.imax) <<< FRAC_W;
		lo_e = imin_q - (Q_W'(cfg.ext_lo) <<< 8);
		hi_e = imax_q + (Q_W'(cfg.ext_hi) <<< 8);
		lo_o = imin_q + (MRM_Q <<< FRAC_W) + CMIN_Q - (Q_W'(cfg.off_lo) <<< 8);
		hi_o = imax_q - (MRP_Q <<< FRAC_W) + CMAX_Q + (Q_W'(cfg.off_hi) <<< 8);
		if (SP_C > span) begin
			st_nx = ST_TINY;
		end else if (cfg.spacing == '0) begin
			st_nx = ST_DXZERO;
		end else if (q_s1 < lo_e) begin
			st_nx = ST_BELOW;
		end else if (q_s1 > hi_e) begin
			st_nx = ST_ABOVE;
		end else if (q_s1 < lo_o) begin
			st_nx = ST_BELOW;
		end else if (q_s1 > hi_o) begin
			st_nx = ST_ABOVE;
		end else begin
			st_nx = ST_OK;
		end
		if (EVEN) begin
			c_full = q_s1 >>> FRAC_W;
		end else if (!q_s1[Q_W-1]) begin
			c_full = (q_s1 + HALF_Q) >>> FRAC_W;
		end else begin
			half_t = (-q_s1 + HALF_Q) >>> FRAC_W;
			c_full = -half_t;
		end
	end

	always_comb begin
		c_lo = C_W'(cfg.imin) + MRM_C;
		c_hi = C_W'(cfg.imax) - MRP_C;
		c_cl = c_s2;
		if (c_cl < c_lo) begin
			c_cl = c_lo;
		end
		if (c_cl > c_hi) begin
			c_cl = c_hi;
		end
		rel_full = q_s2 - (Q_W'(c_cl) <<< FRAC_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d_in.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1  <= q_nx;
			q_s2  <= q_s1;
			st_s2 <= st_nx;
			c_s2  <= c_full[C_W-1:0];
			status_s3 <= st_s2;
			if (st_s2 == ST_OK) begin
				center_s3 <= c_cl[INDEX_W-1:0];
				rel_s3    <= rel_full[COORD_W-1:0];
			end else begin
				center_s3 <= '0;
				rel_s3    <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/interp_stencil_placement_unit.sv -----
// channel | signals                              | direction
// in      | in_valid, in_stall, coord            | request in
// out     | out_valid, out_stall, status,        | request out
//         | center_index, rel_offset             |
// cfg     | cfg_valid, cfg_ready, cfg_index,     | write in
//         | cfg_data                             |
// One request per cycle unless stalled. Stages: input register, 13 divider
// stages of 4 quotient bits each, then sign fix, checks and clamp stages.
// The long division sets the depth. Reset clears valid bits and loads
// register defaults. A stall with out_valid high freezes the whole pipeline.
`default_nettype none
module interp_stencil_placement_unit
	import isp_pkg::*;
#(
	parameter int STENCIL_POINTS = STENCIL_POINTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic signed [COORD_W-1:0]   coord,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [STATUS_W-1:0]              status,
	output logic signed [INDEX_W-1:0]        center_index,
	output logic signed [COORD_W-1:0]        rel_offset,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [3:0]                  cfg_index,
	input  wire logic [31:0]                 cfg_data
);

	cfg_t        cfg_q;
	logic        en;
	logic [31:0] dmag;
	div_t        chain [DIV_STAGES+1];
	div_t        in_s1;
	logic signed [COORD_W:0] diff;
	logic [COORD_W:0]        dabs;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin  <= '0;
			cfg_q.spacing <= 32'sd65536;
			cfg_q.imin    <= '0;
			cfg_q.imax    <= 16'sd1023;
			cfg_q.off_lo  <= '0;
			cfg_q.off_hi  <= '0;
			cfg_q.ext_lo  <= '0;
			cfg_q.ext_hi  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ORIGIN:  cfg_q.origin  <= cfg_data;
				CFG_SPACING: cfg_q.spacing <= cfg_data;
				CFG_IMIN:    cfg_q.imin    <= cfg_data[INDEX_W-1:0];
				CFG_IMAX:    cfg_q.imax    <= cfg_data[INDEX_W-1:0];
				CFG_OFF_LO:  cfg_q.off_lo  <= cfg_data[TOL_W-1:0];
				CFG_OFF_HI:  cfg_q.off_hi  <= cfg_data[TOL_W-1:0];
				CFG_EXT_LO:  cfg_q.ext_lo  <= cfg_data[TOL_W-1:0];
				CFG_EXT_HI:  cfg_q.ext_hi  <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign dmag = cfg_q.spacing[COORD_W-1] ? 32'(-cfg_q.spacing) : cfg_q.spacing;

	always_comb begin
		diff = (COORD_W+1)'(coord) - (COORD_W+1)'(cfg_q.origin);
		dabs = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1 <= '0;
		end else if (en) begin
			in_s1.vld <= in_valid;
			in_s1.neg <= diff[COORD_W] ^ cfg_q.spacing[COORD_W-1];
			in_s1.rem <= '0;
			in_s1.num <= NUM_W'({dabs, {FRAC_W{1'b0}}});
			in_s1.quo <= '0;
		end
	end

	assign chain[0] = in_s1;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		isp_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.dmag   (dmag),
			.d_in   (chain[g]),
			.d_out  (chain[g+1])
		);
	end

	isp_post #(
		.STENCIL_POINTS (STENCIL_POINTS)
	) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.d_in      (chain[DIV_STAGES]),
		.vld_s3    (out_valid),
		.status_s3 (status),
		.center_s3 (center_index),
		.rel_s3    (rel_offset)
	);

endmodule
`default_nettype wire
